/* src/euler_angles_to_basis_vectors_defines.svh */
// ----------------------------------------------------------------------------
// Euler angles to basis vectors: assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and
// disabled while the asynchronous reset is asserted.
// ----------------------------------------------------------------------------
`ifndef EULER_ANGLES_TO_BASIS_VECTORS_DEFINES_SVH
`define EULER_ANGLES_TO_BASIS_VECTORS_DEFINES_SVH

// expression holds at every edge out of reset
`define EABV_ASSERT_HOLDS(name, clk, rst_n, expr, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error(msg);

// antecedent implies consequent in the same cycle
`define EABV_ASSERT_IMPLIES(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

/* src/eabv_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eabv_pkg
// Types, constants and the sine table generator shared by the Euler angle
// to basis vector pipeline.
// ----------------------------------------------------------------------------
package eabv_pkg;

	localparam int ANGLE_BITS_DEF       = 16;
	localparam int TABLE_INDEX_BITS_DEF = 10;
	localparam int FIELD_W              = 16;
	localparam int SIN_W                = 15;
	localparam int ONE_Q14              = 16384;
	localparam real HALF_PI             = 1.57079632679489661923;

	typedef logic signed [FIELD_W-1:0] q14_t;

	typedef struct packed {
		logic en_s1;
		logic en_s2;
		logic en_s3;
		logic en_s4;
		logic en_s5;
		logic vld_s2;
		logic vld_s5;
	} pipe_ctl_t;

	// last field in the lowest bits
	typedef struct packed {
		q14_t up_z;
		q14_t up_y;
		q14_t up_x;
		q14_t right_z;
		q14_t right_y;
		q14_t right_x;
		q14_t forward_z;
		q14_t forward_y;
		q14_t forward_x;
	} basis_t;

	// round(16384 * sin(pi/2 * q / 2^(idx_bits-2)))
	function automatic int quarter_sine(int idx_bits, int q);
		real scale;
		real x;
		int  k;
		scale = 1.0;
		for (k = 0; k < idx_bits - 2; k++) begin
			scale = scale * 0.5;
		end
		x = HALF_PI * real'(q) * scale;
		return $rtoi(16384.0 * $sin(x) + 0.5);
	endfunction

endpackage

/* src/euler_angles_to_basis_vectors.sv */
`timescale 1ns / 1ps
`include "euler_angles_to_basis_vectors_defines.svh"
// ----------------------------------------------------------------------------
// euler_angles_to_basis_vectors
// Yaw, pitch and roll binary angles in; forward, right and up Q2.14 out.
// ----------------------------------------------------------------------------
// Input beats arrive on the s_ channel: three 16-bit binary angles, 65536
// units per turn. Each accepted beat yields exactly one output beat on the
// m_ channel carrying nine signed Q2.14 components, in input order.
// Five register stages: fold angle, table read, pair products, triple
// products, saturating sums. Throughput is one beat per cycle while the
// output is not stalled by m_tready.
// Each stage advances whenever it is empty or the stage after it advances,
// so bubbles close up under backpressure; s_tready drops only when all five
// stages hold beats and m_tready is low. A stall holds the run of full
// stages back from the output; nothing is dropped or repeated.
// Reset clears the valid bits only; the data registers are not reset and
// the sine table is a constant ROM that needs no initialization.
// ----------------------------------------------------------------------------
module euler_angles_to_basis_vectors
	import eabv_pkg::*;
#(
	parameter int ANGLE_BITS       = ANGLE_BITS_DEF,
	parameter int TABLE_INDEX_BITS = TABLE_INDEX_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// yaw_angle[15:0], pitch_angle[31:16], roll_angle[47:32]
	input  logic [3*FIELD_W-1:0] s_tdata,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// forward_x, forward_y, forward_z, right_x, right_y, right_z,
	// up_x, up_y, up_z; 16 bits each from bit 0 up
	output logic [9*FIELD_W-1:0] m_tdata
);

	logic      v_s1_q, v_s2_q, v_s3_q, v_s4_q, v_s5_q;
	pipe_ctl_t ctl;
	q14_t      sy, cy, sp, cp, sr, cr;
	basis_t    basis;

	assign ctl.en_s5  = !v_s5_q || m_tready;
	assign ctl.en_s4  = !v_s4_q || ctl.en_s5;
	assign ctl.en_s3  = !v_s3_q || ctl.en_s4;
	assign ctl.en_s2  = !v_s2_q || ctl.en_s3;
	assign ctl.en_s1  = !v_s1_q || ctl.en_s2;
	assign ctl.vld_s2 = v_s2_q;
	assign ctl.vld_s5 = v_s5_q;

	assign s_tready = ctl.en_s1;
	assign m_tvalid = v_s5_q;
	assign m_tdata  = basis;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1_q <= 1'b0;
			v_s2_q <= 1'b0;
			v_s3_q <= 1'b0;
			v_s4_q <= 1'b0;
			v_s5_q <= 1'b0;
		end else begin
			if (ctl.en_s1) v_s1_q <= s_tvalid;
			if (ctl.en_s2) v_s2_q <= v_s1_q;
			if (ctl.en_s3) v_s3_q <= v_s2_q;
			if (ctl.en_s4) v_s4_q <= v_s3_q;
			if (ctl.en_s5) v_s5_q <= v_s4_q;
		end
	end

	eabv_trig #(
		.ANGLE_BITS       (ANGLE_BITS),
		.TABLE_INDEX_BITS (TABLE_INDEX_BITS)
	) u_trig_yaw (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.angle   (s_tdata[0 +: FIELD_W]),
		.sin_val (sy),
		.cos_val (cy)
	);

	eabv_trig #(
		.ANGLE_BITS       (ANGLE_BITS),
		.TABLE_INDEX_BITS (TABLE_INDEX_BITS)
	) u_trig_pitch (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.angle   (s_tdata[FIELD_W +: FIELD_W]),
		.sin_val (sp),
		.cos_val (cp)
	);

	eabv_trig #(
		.ANGLE_BITS       (ANGLE_BITS),
		.TABLE_INDEX_BITS (TABLE_INDEX_BITS)
	) u_trig_roll (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.angle   (s_tdata[2*FIELD_W +: FIELD_W]),
		.sin_val (sr),
		.cos_val (cr)
	);

	eabv_basis u_basis (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.sy     (sy),
		.cy     (cy),
		.sp     (sp),
		.cp     (cp),
		.sr     (sr),
		.cr     (cr),
		.basis  (basis)
	);

	`EABV_ASSERT_IMPLIES(a_full_on_stall, clk, arst_n, !s_tready,
		v_s1_q && v_s2_q && v_s3_q && v_s4_q && v_s5_q && !m_tready,
		"input stalled while the pipeline has a free stage")

endmodule

/* src/eabv_sin_lut.sv */
`timescale 1ns / 1ps
`include "euler_angles_to_basis_vectors_defines.svh"
// ----------------------------------------------------------------------------
// eabv_sin_lut
// Quarter-wave sine ROM with two registered read ports and sign restore.
// ----------------------------------------------------------------------------
module eabv_sin_lut
	import eabv_pkg::*;
#(
	parameter int TABLE_INDEX_BITS = TABLE_INDEX_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  pipe_ctl_t                   ctl,
	input  logic [TABLE_INDEX_BITS-2:0] addr_a,
	input  logic                        neg_a,
	input  logic [TABLE_INDEX_BITS-2:0] addr_b,
	input  logic                        neg_b,
	output q14_t                        val_a,
	output q14_t                        val_b
);

	localparam int QDEPTH = 1 << (TABLE_INDEX_BITS - 2);

	typedef logic [SIN_W-1:0] lut_t [QDEPTH+1];

	function automatic lut_t build_lut();
		lut_t t;
		for (int q = 0; q <= QDEPTH; q++) begin
			t[q] = SIN_W'(quarter_sine(TABLE_INDEX_BITS, q));
		end
		return t;
	endfunction

	localparam lut_t LUT = build_lut();

	q14_t mag_a;
	q14_t mag_b;
	q14_t rd_a_s2;
	q14_t rd_b_s2;

	assign mag_a = q14_t'({1'b0, LUT[addr_a]});
	assign mag_b = q14_t'({1'b0, LUT[addr_b]});

	always_ff @(posedge clk) begin
		if (ctl.en_s2) begin
			rd_a_s2 <= neg_a ? -mag_a : mag_a;
			rd_b_s2 <= neg_b ? -mag_b : mag_b;
		end
	end

	assign val_a = rd_a_s2;
	assign val_b = rd_b_s2;

	`EABV_ASSERT_IMPLIES(a_lut_range, clk, arst_n, ctl.vld_s2,
		rd_a_s2 <= q14_t'(ONE_Q14) && rd_a_s2 >= -q14_t'(ONE_Q14) &&
		rd_b_s2 <= q14_t'(ONE_Q14) && rd_b_s2 >= -q14_t'(ONE_Q14),
		"sine table output out of unit range")

endmodule

/* src/eabv_trig.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eabv_trig
// Binary angle to table index, quadrant fold, then sine and cosine lookup.
// ----------------------------------------------------------------------------
module eabv_trig
	import eabv_pkg::*;
#(
	parameter int ANGLE_BITS       = ANGLE_BITS_DEF,
	parameter int TABLE_INDEX_BITS = TABLE_INDEX_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  pipe_ctl_t          ctl,
	input  logic [FIELD_W-1:0] angle,
	output q14_t               sin_val,
	output q14_t               cos_val
);

	localparam int AW = ANGLE_BITS;
	localparam int TW = TABLE_INDEX_BITS;
	localparam logic [TW-2:0] QUARTER = (TW-1)'(1) << (TW - 2);

	logic [AW-1:0]   angle_m;
	logic [TW-1:0]   idx;
	logic [1:0]      quad_sin;
	logic [1:0]      quad_cos;
	logic [TW-2:0]   rem;
	logic [TW-2:0]   fold_sin;
	logic [TW-2:0]   fold_cos;
	logic [TW-2:0]   addr_sin_s1;
	logic [TW-2:0]   addr_cos_s1;
	logic            neg_sin_s1;
	logic            neg_cos_s1;

	if (AW > FIELD_W) begin : g_ext
		assign angle_m = {{(AW - FIELD_W){1'b0}}, angle};
	end else begin : g_trunc
		assign angle_m = angle[AW-1:0];
	end

	if (AW >= TW) begin : g_shr
		assign idx = angle_m[AW-1 -: TW];
	end else begin : g_shl
		assign idx = {angle_m, {(TW - AW){1'b0}}};
	end

	assign quad_sin = idx[TW-1 -: 2];
	assign quad_cos = quad_sin + 2'd1;
	assign rem      = {1'b0, idx[TW-3:0]};
	assign fold_sin = quad_sin[0] ? QUARTER - rem : rem;
	assign fold_cos = quad_cos[0] ? QUARTER - rem : rem;

	always_ff @(posedge clk) begin
		if (ctl.en_s1) begin
			addr_sin_s1 <= fold_sin;
			addr_cos_s1 <= fold_cos;
			neg_sin_s1  <= quad_sin[1];
			neg_cos_s1  <= quad_cos[1];
		end
	end

	eabv_sin_lut #(
		.TABLE_INDEX_BITS(TABLE_INDEX_BITS)
	) u_lut (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.addr_a (addr_sin_s1),
		.neg_a  (neg_sin_s1),
		.addr_b (addr_cos_s1),
		.neg_b  (neg_cos_s1),
		.val_a  (sin_val),
		.val_b  (cos_val)
	);

endmodule

/* src/eabv_basis.sv */
`timescale 1ns / 1ps
`include "euler_angles_to_basis_vectors_defines.svh"
// ----------------------------------------------------------------------------
// eabv_basis
// Q2.14 products, triple products and saturating sums for the three
// basis vectors, over three register stages.
// ----------------------------------------------------------------------------
module eabv_basis
	import eabv_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  pipe_ctl_t ctl,
	input  q14_t      sy,
	input  q14_t      cy,
	input  q14_t      sp,
	input  q14_t      cp,
	input  q14_t      sr,
	input  q14_t      cr,
	output basis_t    basis
);

	typedef logic signed [2*FIELD_W-1:0] prod_t;
	typedef logic signed [FIELD_W:0]     sum_t;

	function automatic q14_t qshift(prod_t p);
		prod_t s;
		s = p >>> 14;
		return s[FIELD_W-1:0];
	endfunction

	function automatic q14_t sat(sum_t v);
		if (v > sum_t'(ONE_Q14)) begin
			return q14_t'(ONE_Q14);
		end
		if (v < -sum_t'(ONE_Q14)) begin
			return -q14_t'(ONE_Q14);
		end
		return v[FIELD_W-1:0];
	endfunction

	prod_t p_srsp, p_crsp, p_sycp, p_cycp, p_srcp, p_crcp;
	prod_t p_crcy, p_crnsy, p_nsrcy, p_srsy;
	prod_t p_rx, p_rz, p_ux, p_uz;

	q14_t srsp_s3, crsp_s3, sy_s3, cy_s3;
	q14_t fx_s3, fy_s3, fz_s3, ry_s3, uy_s3;
	q14_t crcy_s3, crnsy_s3, nsrcy_s3, srsy_s3;

	q14_t rx_s4, rz_s4, ux_s4, uz_s4;
	q14_t crcy_s4, crnsy_s4, nsrcy_s4, srsy_s4;
	q14_t fx_s4, fy_s4, fz_s4, ry_s4, uy_s4;

	basis_t basis_s5;
	sum_t   rx_sum, rz_sum, ux_sum, uz_sum;

	assign p_srsp  = sr * sp;
	assign p_crsp  = cr * sp;
	assign p_sycp  = sy * cp;
	assign p_cycp  = cy * cp;
	assign p_srcp  = sr * cp;
	assign p_crcp  = cr * cp;
	assign p_crcy  = cr * cy;
	assign p_crnsy = -(cr * sy);
	assign p_nsrcy = -(sr * cy);
	assign p_srsy  = sr * sy;

	always_ff @(posedge clk) begin
		if (ctl.en_s3) begin
			srsp_s3  <= qshift(p_srsp);
			crsp_s3  <= qshift(p_crsp);
			sy_s3    <= sy;
			cy_s3    <= cy;
			fx_s3    <= qshift(p_sycp);
			fy_s3    <= -sp;
			fz_s3    <= qshift(p_cycp);
			ry_s3    <= qshift(p_srcp);
			uy_s3    <= qshift(p_crcp);
			crcy_s3  <= qshift(p_crcy);
			crnsy_s3 <= qshift(p_crnsy);
			nsrcy_s3 <= qshift(p_nsrcy);
			srsy_s3  <= qshift(p_srsy);
		end
	end

	assign p_rx = srsp_s3 * sy_s3;
	assign p_rz = srsp_s3 * cy_s3;
	assign p_ux = crsp_s3 * sy_s3;
	assign p_uz = crsp_s3 * cy_s3;

	always_ff @(posedge clk) begin
		if (ctl.en_s4) begin
			rx_s4    <= qshift(p_rx);
			rz_s4    <= qshift(p_rz);
			ux_s4    <= qshift(p_ux);
			uz_s4    <= qshift(p_uz);
			crcy_s4  <= crcy_s3;
			crnsy_s4 <= crnsy_s3;
			nsrcy_s4 <= nsrcy_s3;
			srsy_s4  <= srsy_s3;
			fx_s4    <= fx_s3;
			fy_s4    <= fy_s3;
			fz_s4    <= fz_s3;
			ry_s4    <= ry_s3;
			uy_s4    <= uy_s3;
		end
	end

	assign rx_sum = sum_t'(rx_s4) + sum_t'(crcy_s4);
	assign rz_sum = sum_t'(rz_s4) + sum_t'(crnsy_s4);
	assign ux_sum = sum_t'(ux_s4) + sum_t'(nsrcy_s4);
	assign uz_sum = sum_t'(uz_s4) + sum_t'(srsy_s4);

	always_ff @(posedge clk) begin
		if (ctl.en_s5) begin
			basis_s5.forward_x <= fx_s4;
			basis_s5.forward_y <= fy_s4;
			basis_s5.forward_z <= fz_s4;
			basis_s5.right_x   <= sat(rx_sum);
			basis_s5.right_y   <= ry_s4;
			basis_s5.right_z   <= sat(rz_sum);
			basis_s5.up_x      <= sat(ux_sum);
			basis_s5.up_y      <= uy_s4;
			basis_s5.up_z      <= sat(uz_sum);
		end
	end

	assign basis = basis_s5;

	`EABV_ASSERT_IMPLIES(a_right_sat, clk, arst_n, ctl.vld_s5,
		basis_s5.right_x <= q14_t'(ONE_Q14) && basis_s5.right_x >= -q14_t'(ONE_Q14) &&
		basis_s5.right_z <= q14_t'(ONE_Q14) && basis_s5.right_z >= -q14_t'(ONE_Q14),
		"right vector sum escaped saturation")
	`EABV_ASSERT_IMPLIES(a_up_sat, clk, arst_n, ctl.vld_s5,
		basis_s5.up_x <= q14_t'(ONE_Q14) && basis_s5.up_x >= -q14_t'(ONE_Q14) &&
		basis_s5.up_z <= q14_t'(ONE_Q14) && basis_s5.up_z >= -q14_t'(ONE_Q14),
		"up vector sum escaped saturation")

endmodule
